### hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

    localparam int DATA_WIDTH_DEF    = 32;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int SAMPLE_PERIOD_RST = 655;
    localparam int CFG_IDX_W         = 3;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_FILTER_TAU    = 3'd3,
        REG_SAMPLE_PERIOD = 3'd4,
        REG_OUT_MIN       = 3'd5,
        REG_OUT_MAX       = 3'd6
    } t_reg_idx;

    // datapath micro-ops
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_PREP2,
        OP_MUL_P,
        OP_MUL_KI,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_T,
        OP_NUM,
        OP_DIV,
        OP_CLAMP,
        OP_DERIV,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_PREP2,
        S_MUL_P,
        S_MUL_KI,
        S_MUL_A,
        S_MUL_B,
        S_MUL_T,
        S_NUM,
        S_DIV,
        S_CLAMP,
        S_WAIT,
        S_DERIV,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
    } t_sts;

endpackage

### hw/rtl/pid_controller_antiwindup.sv
// PID controller with trapezoidal integrator, anti-windup and filtered derivative.
// Slave stream: one beat = {sensed, target}, signed fixed point with FRAC_BITS
// fraction bits, target in the low DATA_WIDTH bits. Master stream: one beat per
// input beat, the clamped drive value in the low DATA_WIDTH bits.
// Config port: write i_cfg_wdata to register i_cfg_idx when i_cfg_we is high:
// 0 gain_p, 1 gain_i, 2 gain_d, 3 filter_tau, 4 sample_period, 5 out_min,
// 6 out_max; other indexes are ignored. Write only while the block is idle.
// A new input beat is accepted only in the idle state, once the previous result
// has been written to the output register. The serial restoring divider of the
// derivative filter, one quotient bit per cycle, limits the throughput; the
// other steps share one multiplier, one per cycle.
// The output register holds a finished beat while the sink stalls; the next
// input beat is still accepted and worked on, and its result waits for the
// output register to drain. Synchronous reset restores the register defaults
// and clears integrator, derivative filter and sample history.
module pid_controller_antiwindup #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF,
    localparam int IN_TW     = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [IN_TW-1:0]                i_s_axis_tdata,  // target, sensed
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_TW-1:0]               o_m_axis_tdata,  // drive
    input  logic                            i_cfg_we,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]           i_cfg_wdata
);

    pidaw_pkg::t_cmd             w_cmd;
    pidaw_pkg::t_sts             w_sts;
    logic signed [DATA_WIDTH-1:0] w_drive;

    pidaw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pidaw_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_target    (i_s_axis_tdata[DATA_WIDTH-1:0]),
        .i_sensed    (i_s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .o_drive     (w_drive),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    assign o_m_axis_tdata = OUT_TW'($unsigned(w_drive));

endmodule

### hw/rtl/pidaw_div.sv
module pidaw_div #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DATA_WIDTH-1:0]        i_mag,   // |numerator|
    input  logic                         i_neg,
    input  logic [DATA_WIDTH-1:0]        i_den,
    output logic                         o_busy,
    output logic signed [DATA_WIDTH-1:0] o_quot   // signed, saturated
);

    localparam int DW    = DATA_WIDTH;
    localparam int N     = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_W = $clog2(N + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [N-1:0]     r_dvd;   // dividend shifts out, quotient shifts in
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;

    logic [DW:0]      w_trial;
    logic             w_fit;
    logic [DW:0]      w_diff;

    assign w_trial = {r_rem, r_dvd[N-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[N-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);

    always_comb begin
        if (!r_neg) begin
            if (r_dvd[N-1:DW-1] != '0) begin
                o_quot = {1'b0, {(DW-1){1'b1}}};
            end else begin
                o_quot = r_dvd[DW-1:0];
            end
        end else begin
            if ((r_dvd[N-1:DW] != '0) || (r_dvd[DW-1] && (r_dvd[DW-2:0] != '0))) begin
                o_quot = {1'b1, {(DW-1){1'b0}}};
            end else begin
                o_quot = -r_dvd[DW-1:0];
            end
        end
    end

endmodule

### hw/rtl/pidaw_dp.sv
module pidaw_dp #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pidaw_pkg::t_cmd                i_cmd,
    output pidaw_pkg::t_sts                o_sts,
    input  logic signed [DATA_WIDTH-1:0]   i_target,
    input  logic signed [DATA_WIDTH-1:0]   i_sensed,
    output logic signed [DATA_WIDTH-1:0]   o_drive,
    input  logic                           i_cfg_we,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]          i_cfg_wdata
);

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int WW   = 2 * DATA_WIDTH + 1;
    localparam int SH_W = $clog2(FRAC_BITS + 2);

    localparam logic signed [DW-1:0] MAX_V = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_V = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [WW-1:0] sx(input logic signed [DW-1:0] v);
        return {{(WW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] zx(input logic [DW-2:0] v);
        return {{(WW-DW+1){1'b0}}, v};
    endfunction

    function automatic logic signed [DW-1:0] sat(input logic signed [WW-1:0] x);
        if (x[WW-1:DW-1] == {(WW-DW+1){x[WW-1]}}) begin
            return x[DW-1:0];
        end else if (x[WW-1]) begin
            return MIN_V;
        end else begin
            return MAX_V;
        end
    endfunction

    // configuration
    logic signed [DW-1:0] r_gain_p, r_gain_i, r_gain_d, r_out_min, r_out_max;
    logic [DW-2:0]        r_tau, r_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= DW'(1) << F;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_tau     <= '0;
            r_sp      <= (DW-1)'(pidaw_pkg::SAMPLE_PERIOD_RST);
            r_out_min <= MIN_V;
            r_out_max <= MAX_V;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidaw_pkg::REG_GAIN_P:        r_gain_p  <= i_cfg_wdata;
                pidaw_pkg::REG_GAIN_I:        r_gain_i  <= i_cfg_wdata;
                pidaw_pkg::REG_GAIN_D:        r_gain_d  <= i_cfg_wdata;
                pidaw_pkg::REG_FILTER_TAU:    r_tau     <= i_cfg_wdata[DW-2:0];
                pidaw_pkg::REG_SAMPLE_PERIOD: r_sp      <= i_cfg_wdata[DW-2:0];
                pidaw_pkg::REG_OUT_MIN:       r_out_min <= i_cfg_wdata;
                pidaw_pkg::REG_OUT_MAX:       r_out_max <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // working registers
    logic signed [DW-1:0]   r_target, r_sensed;
    logic signed [DW-1:0]   r_e, r_dm, r_two_tau, r_s1, r_dtp, r_den;
    logic signed [DW-1:0]   r_p, r_kit, r_a, r_b, r_t, r_num, r_hi, r_lo, r_sum;
    logic signed [DW-1:0]   r_drive;
    logic signed [2*DW-1:0] r_prod;
    // controller state
    logic signed [DW-1:0]   r_integ, r_deriv, r_last_e, r_last_s;

    pidaw_pkg::t_op w_op;
    assign w_op = i_cmd.op;

    // shared multiplier operands
    logic signed [DW-1:0] w_ma, w_mb;
    always_comb begin
        unique case (w_op)
            pidaw_pkg::OP_MUL_KI: begin w_ma = r_gain_i; w_mb = {1'b0, r_sp}; end
            pidaw_pkg::OP_MUL_A:  begin w_ma = r_gain_d; w_mb = r_dm;         end
            pidaw_pkg::OP_MUL_B:  begin w_ma = r_dtp;    w_mb = r_deriv;      end
            pidaw_pkg::OP_MUL_T:  begin w_ma = r_kit;    w_mb = r_s1;         end
            default:              begin w_ma = r_gain_p; w_mb = r_e;          end
        endcase
    end

    // round-to-nearest of the previous product, shift picked by the op
    logic [SH_W-1:0]      w_sh;
    logic signed [WW-1:0] w_pext, w_radd, w_rsh;
    logic signed [DW-1:0] w_rnd;
    always_comb begin
        unique case (w_op)
            pidaw_pkg::OP_MUL_B: w_sh = SH_W'(F - 1);
            pidaw_pkg::OP_NUM:   w_sh = SH_W'(F + 1);
            default:             w_sh = SH_W'(F);
        endcase
        w_pext = {r_prod[2*DW-1], r_prod};
        w_radd = w_pext + (WW'(1) << (w_sh - SH_W'(1)));
        w_rsh  = w_radd >>> w_sh;
        w_rnd  = sat(w_rsh);
    end

    logic signed [DW-1:0] w_drv;
    assign w_drv = sat(sx(r_sum) + sx(r_deriv));

    // divider
    logic                 w_div_busy;
    logic signed [DW-1:0] w_quot;
    logic [DW-1:0]        w_mag;
    assign w_mag = r_num[DW-1] ? DW'(-r_num) : DW'(r_num);

    pidaw_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_op == pidaw_pkg::OP_DIV),
        .i_mag   (w_mag),
        .i_neg   (r_num[DW-1]),
        .i_den   (DW'(r_den)),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign o_sts.div_busy = w_div_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ  <= '0;
            r_deriv  <= '0;
            r_last_e <= '0;
            r_last_s <= '0;
        end else begin
            unique case (w_op)
                pidaw_pkg::OP_DIV: r_integ <= sat(sx(r_integ) + sx(r_t));
                pidaw_pkg::OP_CLAMP: begin
                    // r_hi is never below zero and r_lo never above it, so these limits cannot be inverted
                    if (r_integ > r_hi) begin
                        r_integ <= r_hi;
                    end else if (r_integ < r_lo) begin
                        r_integ <= r_lo;
                    end
                end
                pidaw_pkg::OP_DERIV: r_deriv <= (r_den != '0) ? w_quot : '0;
                pidaw_pkg::OP_OUT: begin
                    r_last_e <= r_e;
                    r_last_s <= r_sensed;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (w_op)
            pidaw_pkg::OP_LOAD: begin
                r_target <= i_target;
                r_sensed <= i_sensed;
            end
            pidaw_pkg::OP_PREP: begin
                r_e       <= sat(sx(r_target) - sx(r_sensed));
                r_dm      <= sat(sx(r_sensed) - sx(r_last_s));
                r_two_tau <= sat(zx(r_tau) <<< 1);
            end
            pidaw_pkg::OP_PREP2: begin
                r_s1  <= sat(sx(r_e) + sx(r_last_e));
                r_dtp <= sat(sx(r_two_tau) - zx(r_sp));
                r_den <= sat(sx(r_two_tau) + zx(r_sp));
            end
            pidaw_pkg::OP_MUL_P: r_prod <= w_ma * w_mb;
            pidaw_pkg::OP_MUL_KI: begin
                r_p    <= w_rnd;
                r_prod <= w_ma * w_mb;
            end
            pidaw_pkg::OP_MUL_A: begin
                r_kit  <= w_rnd;
                r_prod <= w_ma * w_mb;
            end
            pidaw_pkg::OP_MUL_B: begin
                r_a    <= w_rnd;
                r_prod <= w_ma * w_mb;
            end
            pidaw_pkg::OP_MUL_T: begin
                r_b    <= w_rnd;
                r_prod <= w_ma * w_mb;
            end
            pidaw_pkg::OP_NUM: begin
                r_t   <= w_rnd;
                r_num <= sat(sx(r_b) - sx(r_a));
                r_hi  <= (r_out_max > r_p) ? sat(sx(r_out_max) - sx(r_p)) : '0;
                r_lo  <= (r_out_min < r_p) ? sat(sx(r_out_min) - sx(r_p)) : '0;
            end
            pidaw_pkg::OP_DERIV: r_sum <= sat(sx(r_p) + sx(r_integ));
            pidaw_pkg::OP_OUT: begin
                if (w_drv > r_out_max) begin
                    r_drive <= r_out_max;
                end else if (w_drv < r_out_min) begin
                    r_drive <= r_out_min;
                end else begin
                    r_drive <= w_drv;
                end
            end
            default: ;
        endcase
    end

    assign o_drive = r_drive;

endmodule

### hw/rtl/pidaw_ctrl.sv
module pidaw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pidaw_pkg::t_cmd o_cmd,
    input  pidaw_pkg::t_sts i_sts
);

    pidaw_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    // output register can take a new beat
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidaw_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pidaw_pkg::S_IDLE:   if (i_in_valid) n_state = pidaw_pkg::S_PREP;
            pidaw_pkg::S_PREP:   n_state = pidaw_pkg::S_PREP2;
            pidaw_pkg::S_PREP2:  n_state = pidaw_pkg::S_MUL_P;
            pidaw_pkg::S_MUL_P:  n_state = pidaw_pkg::S_MUL_KI;
            pidaw_pkg::S_MUL_KI: n_state = pidaw_pkg::S_MUL_A;
            pidaw_pkg::S_MUL_A:  n_state = pidaw_pkg::S_MUL_B;
            pidaw_pkg::S_MUL_B:  n_state = pidaw_pkg::S_MUL_T;
            pidaw_pkg::S_MUL_T:  n_state = pidaw_pkg::S_NUM;
            pidaw_pkg::S_NUM:    n_state = pidaw_pkg::S_DIV;
            pidaw_pkg::S_DIV:    n_state = pidaw_pkg::S_CLAMP;
            pidaw_pkg::S_CLAMP:  n_state = pidaw_pkg::S_WAIT;
            pidaw_pkg::S_WAIT:   if (!i_sts.div_busy) n_state = pidaw_pkg::S_DERIV;
            pidaw_pkg::S_DERIV:  n_state = pidaw_pkg::S_OUT;
            pidaw_pkg::S_OUT:    if (w_out_free) n_state = pidaw_pkg::S_IDLE;
            default:             n_state = pidaw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op    = pidaw_pkg::OP_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            pidaw_pkg::S_IDLE:   if (i_in_valid) o_cmd.op = pidaw_pkg::OP_LOAD;
            pidaw_pkg::S_PREP:   o_cmd.op = pidaw_pkg::OP_PREP;
            pidaw_pkg::S_PREP2:  o_cmd.op = pidaw_pkg::OP_PREP2;
            pidaw_pkg::S_MUL_P:  o_cmd.op = pidaw_pkg::OP_MUL_P;
            pidaw_pkg::S_MUL_KI: o_cmd.op = pidaw_pkg::OP_MUL_KI;
            pidaw_pkg::S_MUL_A:  o_cmd.op = pidaw_pkg::OP_MUL_A;
            pidaw_pkg::S_MUL_B:  o_cmd.op = pidaw_pkg::OP_MUL_B;
            pidaw_pkg::S_MUL_T:  o_cmd.op = pidaw_pkg::OP_MUL_T;
            pidaw_pkg::S_NUM:    o_cmd.op = pidaw_pkg::OP_NUM;
            pidaw_pkg::S_DIV:    o_cmd.op = pidaw_pkg::OP_DIV;
            pidaw_pkg::S_CLAMP:  o_cmd.op = pidaw_pkg::OP_CLAMP;
            pidaw_pkg::S_DERIV:  o_cmd.op = pidaw_pkg::OP_DERIV;
            pidaw_pkg::S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op    = pidaw_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == pidaw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
